FILE: rtl/core/cafd_pkg.sv
`default_nettype none

package cafd_pkg;

  // frame lengths in payload bytes
  localparam logic [5:0] CMD_PAYLOAD_LEN = 6'd15;
  localparam logic [5:0] ROW_PAYLOAD_LEN = 6'd20;

  // header codes
  localparam logic [7:0] CODE_FIRST      = 8'hF6;
  localparam logic [7:0] CODE_LAST       = 8'hFE;
  localparam logic [7:0] CODE_SHORT_LAST = 8'hFA;
  localparam logic [7:0] CODE_BIAS       = 8'hF5;
  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] XOR_SEED        = 8'hFF;
  localparam logic [2:0] RESYNC_RUN      = 3'd5;

  // last command code with a short payload, as a frame kind
  localparam logic [7:0] SHORT_KIND_MAX_W = CODE_SHORT_LAST - CODE_BIAS;
  localparam logic [3:0] SHORT_KIND_MAX   = SHORT_KIND_MAX_W[3:0];

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_HDR_ERR = 2'd2,
    EV_RESYNC  = 2'd3
  } event_t;

  typedef struct packed {
    logic [2:0] ff_run_count;
    phase_t     phase;
    logic [3:0] kind;
    logic [7:0] row_count;
    logic [4:0] pos_count;
    logic [7:0] xor_acc;
  } dfr_state_t;

  typedef struct packed {
    event_t     event_res;
    logic [3:0] frame_kind;
    logic [7:0] row_index;
    logic [4:0] byte_position;
    logic [7:0] data_byte;
    logic       clear_rows;
    logic       frame_last;
    logic       check_ok;
    logic       dispatch;
  } dfr_result_t;

  localparam dfr_state_t STATE_CLEAR = '{
    ff_run_count: 3'd0,
    phase:        PH_IDLE,
    kind:         4'd0,
    row_count:    8'd0,
    pos_count:    5'd0,
    xor_acc:      XOR_SEED
  };

endpackage

`default_nettype wire

FILE: rtl/core/cafd_step.sv
`default_nettype none

module cafd_step import cafd_pkg::*; (
  input  wire logic [7:0]  rx_byte,
  input  wire dfr_state_t  cur,
  output dfr_state_t       nxt,
  output logic             res_valid,
  output dfr_result_t      res
);

  logic       is_ff;
  logic [2:0] ff_inc;
  logic       resync;
  logic       is_code;
  logic [3:0] kind_w;
  logic       short_frame;
  logic [5:0] frame_len;
  logic [5:0] pos_inc;
  logic [7:0] xor_new;

  // resync run counter
  assign is_ff  = (rx_byte == SYNC_BYTE);
  assign ff_inc = cur.ff_run_count + 3'd1;
  assign resync = is_ff && (ff_inc >= RESYNC_RUN);

  // header decode and payload bookkeeping
  // command codes share the high nibble, so the kind comes from the low nibble
  assign is_code     = (rx_byte >= CODE_FIRST) && (rx_byte <= CODE_LAST);
  assign kind_w      = rx_byte[3:0] - CODE_BIAS[3:0];
  assign short_frame = (cur.kind != 4'd0) && (cur.kind <= SHORT_KIND_MAX);
  assign frame_len   = short_frame ? CMD_PAYLOAD_LEN : ROW_PAYLOAD_LEN;
  assign pos_inc     = {1'b0, cur.pos_count} + 6'd1;
  assign xor_new     = cur.xor_acc ^ rx_byte;

  always_comb begin
    nxt              = cur;
    nxt.ff_run_count = is_ff ? ff_inc : (cur.ff_run_count >> 1);
    res_valid        = 1'b0;
    res              = '0;
    res.row_index    = cur.row_count;
    res.data_byte    = rx_byte;
    res.frame_kind   = cur.kind;

    if (resync) begin
      nxt           = STATE_CLEAR;
      res_valid     = 1'b1;
      res           = '0;
      res.event_res = EV_RESYNC;
      res.data_byte = SYNC_BYTE;
    end else begin
      case (cur.phase)
        PH_IDLE: begin
          if (!is_ff) begin
            res_valid = 1'b1;
            if (is_code) begin
              nxt.kind       = kind_w;
              nxt.pos_count  = 5'd0;
              nxt.xor_acc    = XOR_SEED;
              nxt.phase      = PH_PAYLOAD;
              res.event_res  = EV_HEADER;
              res.frame_kind = kind_w;
              res.clear_rows = (cur.row_count == 8'd0) && (rx_byte > CODE_SHORT_LAST);
            end else if (rx_byte == cur.row_count) begin
              nxt.pos_count  = 5'd0;
              nxt.xor_acc    = XOR_SEED;
              nxt.phase      = PH_PAYLOAD;
              res.event_res  = EV_HEADER;
              res.clear_rows = (cur.row_count == 8'd0);
            end else begin
              nxt.phase      = PH_ERROR;
              res.event_res  = EV_HDR_ERR;
              res.frame_kind = 4'd0;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.event_res     = EV_PAYLOAD;
          res.byte_position = cur.pos_count;
          nxt.xor_acc       = xor_new;
          nxt.pos_count     = pos_inc[4:0];
          if (pos_inc >= frame_len) begin
            res.frame_last = 1'b1;
            if (xor_new != 8'd0) begin
              nxt.phase = PH_ERROR;
            end else begin
              res.check_ok = 1'b1;
              if (cur.kind != 4'd0) begin
                // command frame closes the message
                res.dispatch = 1'b1;
                nxt          = STATE_CLEAR;
              end else begin
                nxt.row_count = cur.row_count + 8'd1;
                nxt.phase     = PH_IDLE;
              end
            end
          end
        end
        default: begin
          // error phase: wait for resync
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/command_action_frame_deframer.sv
// A result word is registered in the output register, or in the skid register while the output is held.
// Throughput: one input word per cycle while the skid register is empty; the state update is combinational.
// A two-entry output register (result plus skid) keeps input flowing for one stalled result.
// Reset: synchronous active-low rst_n clears the deframer state to idle and empties the output.
`default_nettype none

module command_action_frame_deframer import cafd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_event_res,
  output logic [3:0]      out_frame_kind,
  output logic [7:0]      out_row_index,
  output logic [4:0]      out_byte_position,
  output logic [7:0]      out_data_byte,
  output logic            out_clear_rows,
  output logic            out_frame_last,
  output logic            out_check_ok,
  output logic            out_dispatch
);

  dfr_state_t  state_r, state_nxt;
  dfr_result_t step_res;
  logic        step_valid;
  dfr_result_t out_r, skid_r;
  logic        out_valid_r, skid_valid_r;
  logic        accept, push, pop;

  cafd_step u_step (
    .rx_byte   (in_rx_byte),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res_valid (step_valid),
    .res       (step_res)
  );

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign push     = accept && step_valid;
  assign pop      = out_valid_r && out_ready;

  // deframer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // output and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= step_res;
      end else begin
        out_r <= step_res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_r.event_res;
  assign out_frame_kind    = out_r.frame_kind;
  assign out_row_index     = out_r.row_index;
  assign out_byte_position = out_r.byte_position;
  assign out_data_byte     = out_r.data_byte;
  assign out_clear_rows    = out_r.clear_rows;
  assign out_frame_last    = out_r.frame_last;
  assign out_check_ok      = out_r.check_ok;
  assign out_dispatch      = out_r.dispatch;

`ifndef ASSERT_OFF
  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without output word");

  // run counter clears before reaching the resync count
  a_ff_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ff_run_count < RESYNC_RUN)
    else $error("resync run counter out of range");

  // error phase is left only through a resync
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r.phase == PH_ERROR && in_rx_byte != SYNC_BYTE)
      |=> state_r.phase == PH_ERROR)
    else $error("error phase left without resync");
`endif

endmodule

`default_nettype wire

FILE: verif/deframer_checker.sv
`timescale 1ns / 100ps

module deframer_checker import cafd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [1:0] out_event_res,
  input  wire logic [3:0] out_frame_kind,
  input  wire logic [7:0] out_row_index,
  input  wire logic [4:0] out_byte_position,
  input  wire logic [7:0] out_data_byte,
  input  wire logic       out_clear_rows,
  input  wire logic       out_frame_last,
  input  wire logic       out_check_ok,
  input  wire logic       out_dispatch,
  output int              fail_count,
  output int              pending
);

  // predicted deframer state
  logic [2:0] run_ff;
  phase_t     cur_phase;
  logic [3:0] cur_kind;
  logic [7:0] next_row;
  logic [4:0] pay_pos;
  logic [7:0] pay_xor;

  // result words still owed by the block, oldest first
  dfr_result_t pending_results[$];

  task automatic clear_state();
    run_ff    = 3'd0;
    cur_phase = PH_IDLE;
    cur_kind  = 4'd0;
    next_row  = 8'd0;
    pay_pos   = 5'd0;
    pay_xor   = XOR_SEED;
  endtask

  function automatic dfr_result_t make_result(event_t ev, logic [3:0] kind, logic [7:0] row,
                                              logic [4:0] pos, logic [7:0] data, logic clr,
                                              logic last, logic ok, logic disp);
    dfr_result_t r;
    r.event_res     = ev;
    r.frame_kind    = kind;
    r.row_index     = row;
    r.byte_position = pos;
    r.data_byte     = data;
    r.clear_rows    = clr;
    r.frame_last    = last;
    r.check_ok      = ok;
    r.dispatch      = disp;
    return r;
  endfunction

  // advance the predicted state by one received byte
  task automatic deframe_word(input logic [7:0] b);
    logic [5:0] len;
    logic [5:0] nxt;
    logic [3:0] kind;
    logic [7:0] row;
    logic [4:0] pos;
    logic       clr;
    // run of sync bytes, halved by anything else
    if (b == SYNC_BYTE) begin
      run_ff = run_ff + 3'd1;
      if (run_ff >= RESYNC_RUN) begin
        clear_state();
        pending_results.push_back(make_result(EV_RESYNC, 4'd0, 8'd0, 5'd0, SYNC_BYTE,
                                              1'b0, 1'b0, 1'b0, 1'b0));
        return;
      end
    end else begin
      run_ff = run_ff >> 1;
    end

    case (cur_phase)
      PH_IDLE: begin
        // a lone sync byte between frames is dropped
        if (b == SYNC_BYTE) return;
        if (b >= CODE_FIRST && b <= CODE_LAST) begin
          clr       = (next_row == 8'd0) && (b > CODE_SHORT_LAST);
          cur_kind  = 4'(b - CODE_BIAS);
          pay_pos   = 5'd0;
          pay_xor   = XOR_SEED;
          cur_phase = PH_PAYLOAD;
          pending_results.push_back(make_result(EV_HEADER, cur_kind, next_row, 5'd0, b, clr,
                                                1'b0, 1'b0, 1'b0));
        end else if (b == next_row) begin
          clr       = (next_row == 8'd0);
          pay_pos   = 5'd0;
          pay_xor   = XOR_SEED;
          cur_phase = PH_PAYLOAD;
          pending_results.push_back(make_result(EV_HEADER, cur_kind, next_row, 5'd0, b, clr,
                                                1'b0, 1'b0, 1'b0));
        end else begin
          cur_phase = PH_ERROR;
          pending_results.push_back(make_result(EV_HDR_ERR, 4'd0, next_row, 5'd0, b, 1'b0,
                                                1'b0, 1'b0, 1'b0));
        end
      end
      PH_PAYLOAD: begin
        // short payload for the low command codes only
        len  = (cur_kind != 4'd0 && cur_kind <= SHORT_KIND_MAX) ? CMD_PAYLOAD_LEN
                                                                 : ROW_PAYLOAD_LEN;
        kind = cur_kind;
        row  = next_row;
        pos  = pay_pos;
        nxt  = {1'b0, pay_pos} + 6'd1;
        pay_xor = pay_xor ^ b;
        pay_pos = nxt[4:0];
        if (nxt >= len) begin
          if (pay_xor != 8'd0) begin
            cur_phase = PH_ERROR;
            pending_results.push_back(make_result(EV_PAYLOAD, kind, row, pos, b, 1'b0,
                                                  1'b1, 1'b0, 1'b0));
          end else begin
            next_row  = next_row + 8'd1;
            cur_phase = PH_IDLE;
            // a good command frame closes the message
            if (kind != 4'd0) begin
              clear_state();
              pending_results.push_back(make_result(EV_PAYLOAD, kind, row, pos, b, 1'b0,
                                                    1'b1, 1'b1, 1'b1));
            end else begin
              pending_results.push_back(make_result(EV_PAYLOAD, kind, row, pos, b, 1'b0,
                                                    1'b1, 1'b1, 1'b0));
            end
          end
        end else begin
          pending_results.push_back(make_result(EV_PAYLOAD, kind, row, pos, b, 1'b0,
                                                1'b0, 1'b0, 1'b0));
        end
      end
      default: begin
        // error phase: wait for resync
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    dfr_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word arrived with nothing predicted");
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    check_field("event_res", 8'(want.event_res), 8'(out_event_res));
    check_field("frame_kind", 8'(want.frame_kind), 8'(out_frame_kind));
    check_field("row_index", want.row_index, out_row_index);
    check_field("byte_position", 8'(want.byte_position), 8'(out_byte_position));
    check_field("data_byte", want.data_byte, out_data_byte);
    check_field("clear_rows", 8'(want.clear_rows), 8'(out_clear_rows));
    check_field("frame_last", 8'(want.frame_last), 8'(out_frame_last));
    check_field("check_ok", 8'(want.check_ok), 8'(out_check_ok));
    check_field("dispatch", 8'(want.dispatch), 8'(out_dispatch));
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) deframe_word(in_rx_byte);
    end
    pending = pending_results.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cafd_pkg::*;

  localparam int RANDOM_WORDS = 620;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_res;
  logic [3:0] out_frame_kind;
  logic [7:0] out_row_index;
  logic [4:0] out_byte_position;
  logic [7:0] out_data_byte;
  logic       out_clear_rows;
  logic       out_frame_last;
  logic       out_check_ok;
  logic       out_dispatch;
  int         fail_count;
  int         pending;

  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  bit hold_long = 1'b0;
  int words_sent = 0;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  command_action_frame_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_kind   (out_frame_kind),
    .out_row_index    (out_row_index),
    .out_byte_position(out_byte_position),
    .out_data_byte    (out_data_byte),
    .out_clear_rows   (out_clear_rows),
    .out_frame_last   (out_frame_last),
    .out_check_ok     (out_check_ok),
    .out_dispatch     (out_dispatch)
  );

  deframer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_frame_kind   (out_frame_kind),
    .out_row_index    (out_row_index),
    .out_byte_position(out_byte_position),
    .out_data_byte    (out_data_byte),
    .out_clear_rows   (out_clear_rows),
    .out_frame_last   (out_frame_last),
    .out_check_ok     (out_check_ok),
    .out_dispatch     (out_dispatch),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // header plus payload, last byte closing the xor unless a bad check is wanted
  task automatic send_frame(input logic [7:0] hdr, input bit good);
    int         len;
    logic [7:0] acc;
    logic [7:0] d;
    len = (hdr >= CODE_FIRST && hdr <= CODE_SHORT_LAST) ? int'(CMD_PAYLOAD_LEN)
                                                        : int'(ROW_PAYLOAD_LEN);
    send_word(hdr);
    acc = XOR_SEED;
    for (int i = 0; i < len - 1; i++) begin
      d = 8'($urandom);
      acc = acc ^ d;
      send_word(d);
    end
    d = acc;
    if (!good) d = d ^ 8'($urandom_range(1, 255));
    send_word(d);
  endtask

  task automatic send_resync();
    repeat (RESYNC_RUN) send_word(SYNC_BYTE);
  endtask

  // some junk that the error phase drops, then a resync run
  task automatic recover();
    repeat ($urandom_range(0, 3)) send_word(8'($urandom));
    send_resync();
  endtask

  // row frames from zero, closed by a command frame
  task automatic run_message();
    int         rows;
    logic [7:0] row;
    bit         good;
    rows = $urandom_range(0, 4);
    row  = 8'd0;
    if ($urandom_range(0, 7) == 0) send_word(SYNC_BYTE);
    for (int r = 0; r < rows; r++) begin
      good = ($urandom_range(0, 9) != 0);
      send_frame(row, good);
      if (!good) begin
        recover();
        return;
      end
      row++;
    end
    good = ($urandom_range(0, 9) != 0);
    send_frame(8'($urandom_range(CODE_FIRST, CODE_LAST)), good);
    if (!good) recover();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_long = 1'b0;
      end
      stall = pick_gap(rx_stall_on);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] opening[$];
    int         msg;
    int         pick;
    int         random_goal;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // idle sync byte, header error with ignored byte and resync,
    // resync inside a row frame after a halved run, resync inside a command frame
    opening = {SYNC_BYTE, 8'h80, 8'h00, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE,
               SYNC_BYTE, 8'h00, 8'h7F, 8'h00, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE,
               SYNC_BYTE, 8'h7F, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, CODE_LAST, SYNC_BYTE,
               SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE};
    foreach (opening[i]) send_word(opening[i]);

    // random messages with some noise and aborted frames
    random_goal = words_sent + RANDOM_WORDS;
    msg = 0;
    while (words_sent < random_goal) begin
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      if (msg == 2) hold_long = 1'b1;
      if (msg == 4) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        run_message();
      end else if (pick < 90) begin
        send_word(8'($urandom));
        recover();
      end else begin
        send_word(8'd0);
        repeat ($urandom_range(1, 10)) send_word(8'($urandom));
        send_resync();
      end
      msg++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cafd_pkg.sv
rtl/core/cafd_step.sv
rtl/core/command_action_frame_deframer.sv
verif/deframer_checker.sv
verif/testbench.sv
